// ===== rtl/core/trapezoid_charge_energy_counter_macros.svh =====
// Assertion macros for the trapezoid charge and energy counter.
`ifndef TRAPEZOID_CHARGE_ENERGY_COUNTER_MACROS_SVH
`define TRAPEZOID_CHARGE_ENERGY_COUNTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define TCEC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcec assertion failed");

// Next-cycle implication, disabled during reset.
`define TCEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcec assertion failed");

`else

`define TCEC_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCEC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/tcec_pkg.sv =====
// Shared types, constants and functions of the trapezoid charge and energy counter.
`default_nettype none

package tcec_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = 51;
  localparam int ACC_W   = 64;

  localparam logic [15:0] MAX_STEP_RESET = 16'd1000;

  // Register index (byte address / 4)
  localparam logic REG_MAX_STEP = 1'b0;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_BACK = 2'd1,
    FAULT_LONG = 2'd2
  } fault_t;

  // Input word: one timestamped sample
  typedef struct packed {
    logic        [31:0] time_ms;
    logic        [15:0] volt_mv;
    logic signed [15:0] amp_ma;
  } sample_t;

  // Output word: state after the sample
  typedef struct packed {
    logic signed [63:0] charge_sum;
    logic signed [63:0] energy_sum;
    logic               run_ok;
    logic        [1:0]  fault_code;
    logic        [31:0] stamp_out;
  } result_t;

  // Signed add that clamps at the 64-bit limits
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tcec_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none

module tcec_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [tcec_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [tcec_pkg::MUL_B_W-1:0] op_b,
  output      logic signed [tcec_pkg::PROD_W-1:0]  prod
);

  logic signed [tcec_pkg::PROD_W-1:0] full;

  // product fits in PROD_W bits for the operand ranges used
  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trapezoid_charge_energy_counter.sv =====
// Trapezoid charge and energy counter: top level.
//
// Usage: each sample word (time_ms, volt_mv, amp_ma) enters on the sample
// valid/ready channel; each sample gives exactly one result word on the
// result valid/ready channel with both accumulators, the run_ok flag, the
// last fault code and the stamp of the last sample that was not rejected.
// Sequence: an integrated step runs check, four multiplies on one shared
// multiplier and two saturating adds on one shared adder before its result;
// a first sample or a rejected step goes from check straight to the result.
// A new sample is taken only once the last one is through, and the shared
// multiplier sets the length of an integrated step.
// The result sits in an output register; if the receiver stalls, the
// finished work waits in the last step and no new sample is taken.
// Reset (rst, synchronous): accumulators and stored sample cleared,
// run_ok set, fault code none, max_step_ms back to 1000, no result pending.
// max_step_ms is written over the APB port at byte address 0.
`default_nettype none

`include "trapezoid_charge_energy_counter_macros.svh"

module trapezoid_charge_energy_counter (
  input  wire logic              clk,
  input  wire logic              rst,
  // sample channel
  input  wire logic              sample_valid,
  output      logic              sample_ready,
  input  wire tcec_pkg::sample_t sample,
  // result channel
  output      logic              result_valid,
  input  wire logic              result_ready,
  output      tcec_pkg::result_t result,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_MUL0  = 8'b0000_0100,
    ST_MUL1  = 8'b0000_1000,
    ST_MULQ  = 8'b0001_0000,
    ST_MULE  = 8'b0010_0000,
    ST_ACCE  = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [15:0] max_step;

  // stored sample and running state
  logic        [31:0] prev_time;
  logic        [15:0] prev_volt;
  logic signed [15:0] prev_amp;
  logic               seen_first;
  logic signed [tcec_pkg::ACC_W-1:0] charge_acc;
  logic signed [tcec_pkg::ACC_W-1:0] energy_acc;
  logic               ok_flag;
  tcec_pkg::fault_t   last_fault;

  // sample being worked on
  logic        [31:0] cur_time;
  logic        [15:0] cur_volt;
  logic signed [15:0] cur_amp;
  logic        [15:0] dt;
  logic signed [16:0] isum;
  logic signed [tcec_pkg::MUL_A_W-1:0] psum;

  logic signed [tcec_pkg::MUL_A_W-1:0] op_a;
  logic signed [tcec_pkg::MUL_B_W-1:0] op_b;
  logic                                mul_en;
  logic signed [tcec_pkg::PROD_W-1:0]  prod;

  logic        [31:0] dt_full;
  logic               step_back;
  logic               step_long;
  logic signed [tcec_pkg::ACC_W-1:0] acc_sel;
  logic signed [tcec_pkg::ACC_W-1:0] acc_sum;
  logic               cfg_write;
  logic               out_free;

  // APB register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == tcec_pkg::REG_MAX_STEP) ? {16'd0, max_step} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= tcec_pkg::MAX_STEP_RESET;
    end else if (cfg_write && paddr[2] == tcec_pkg::REG_MAX_STEP) begin
      max_step <= pwdata[15:0];
    end
  end

  // step checks
  assign dt_full   = cur_time - prev_time;
  assign step_back = cur_time < prev_time;
  assign step_long = dt_full > {16'd0, max_step};

  assign sample_ready = (state == ST_IDLE);
  assign out_free     = !result_valid || result_ready;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (sample_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!seen_first || step_back || step_long) state_next = ST_FIN;
        else                                       state_next = ST_MUL0;
      end
      ST_MUL0:  state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MULQ;
      ST_MULQ:  state_next = ST_MULE;
      ST_MULE:  state_next = ST_ACCE;
      ST_ACCE:  state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier operand select
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    mul_en = 1'b0;
    unique case (state)
      ST_MUL0: begin
        op_a   = tcec_pkg::MUL_A_W'($signed({1'b0, prev_volt}));
        op_b   = tcec_pkg::MUL_B_W'(prev_amp);
        mul_en = 1'b1;
      end
      ST_MUL1: begin
        op_a   = tcec_pkg::MUL_A_W'($signed({1'b0, cur_volt}));
        op_b   = tcec_pkg::MUL_B_W'(cur_amp);
        mul_en = 1'b1;
      end
      ST_MULQ: begin
        op_a   = tcec_pkg::MUL_A_W'(isum);
        op_b   = $signed({1'b0, dt});
        mul_en = 1'b1;
      end
      ST_MULE: begin
        op_a   = psum;
        op_b   = $signed({1'b0, dt});
        mul_en = 1'b1;
      end
      default: begin
        op_a   = '0;
        op_b   = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  tcec_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // shared saturating adder: charge in MULE, energy in ACCE
  assign acc_sel = (state == ST_MULE) ? charge_acc : energy_acc;
  assign acc_sum = tcec_pkg::sat_add(acc_sel, tcec_pkg::ACC_W'(prod));

  // working registers
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      cur_time <= sample.time_ms;
      cur_volt <= sample.volt_mv;
      cur_amp  <= sample.amp_ma;
    end
    if (state == ST_CHECK) begin
      dt <= dt_full[15:0];
    end
    if (state == ST_MUL0) begin
      isum <= 17'(prev_amp) + 17'(cur_amp);
    end
    // psum collects v0*i0 then adds v1*i1
    if (state == ST_MUL1) begin
      psum <= tcec_pkg::MUL_A_W'(prod);
    end else if (state == ST_MULQ) begin
      psum <= psum + tcec_pkg::MUL_A_W'(prod);
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time  <= '0;
      prev_volt  <= '0;
      prev_amp   <= '0;
      seen_first <= 1'b0;
      charge_acc <= '0;
      energy_acc <= '0;
      ok_flag    <= 1'b1;
      last_fault <= tcec_pkg::FAULT_NONE;
    end else begin
      if (state == ST_CHECK) begin
        if (!seen_first) begin
          seen_first <= 1'b1;
          prev_time  <= cur_time;
          prev_volt  <= cur_volt;
          prev_amp   <= cur_amp;
        end else if (step_back) begin
          ok_flag    <= 1'b0;
          last_fault <= tcec_pkg::FAULT_BACK;
        end else if (step_long) begin
          ok_flag    <= 1'b0;
          last_fault <= tcec_pkg::FAULT_LONG;
        end
      end
      if (state == ST_MULE) begin
        charge_acc <= acc_sum;
      end
      if (state == ST_ACCE) begin
        energy_acc <= acc_sum;
        prev_time  <= cur_time;
        prev_volt  <= cur_volt;
        prev_amp   <= cur_amp;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      result.charge_sum <= charge_acc;
      result.energy_sum <= energy_acc;
      result.run_ok     <= ok_flag;
      result.fault_code <= last_fault;
      result.stamp_out  <= prev_time;
    end
  end

  // checks
  `TCEC_ASSERT_NEXT(a_ok_sticky, clk, rst, !ok_flag, !ok_flag)
  `TCEC_ASSERT_NOW(a_fault_clears_ok, clk, rst, last_fault != tcec_pkg::FAULT_NONE, !ok_flag)
  `TCEC_ASSERT_NEXT(a_accept_to_check, clk, rst, sample_valid && sample_ready, state == ST_CHECK)
  `TCEC_ASSERT_NEXT(a_prev_follows, clk, rst, state == ST_ACCE, prev_time == cur_time)

endmodule

`default_nettype wire

// ===== dv/tb_trapezoid_charge_energy_counter.sv =====
// Self-checking testbench for the trapezoid charge and energy counter.
`default_nettype none

module tb_trapezoid_charge_energy_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  MAX_STEP_ADDR  = {tcec_pkg::REG_MAX_STEP, 2'b00};
  localparam logic [2:0]  SPARE_ADDR     = 3'd4;   // no register lives here
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam logic [15:0] VOLT_TOP       = 16'hFFFF;
  localparam logic [15:0] AMP_MOST_NEG   = 16'h8000;
  localparam logic [15:0] AMP_MOST_POS   = 16'h7FFF;
  localparam logic [15:0] STEP_TOP       = 16'hFFFF;

  logic              clk;
  logic              rst          = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_ready;
  tcec_pkg::sample_t sample_word  = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  tcec_pkg::result_t result_word;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [2:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;

  trapezoid_charge_energy_counter u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mirror of the counter state
  logic [31:0]        last_stamp   = '0;
  logic [15:0]        last_volt    = '0;
  logic signed [15:0] last_amp     = '0;
  bit                 have_sample  = 1'b0;
  longint             charge_tot   = 0;
  longint             energy_tot   = 0;
  bit                 run_good     = 1'b1;
  tcec_pkg::fault_t   recent_fault = tcec_pkg::FAULT_NONE;
  logic [15:0]        step_limit   = tcec_pkg::MAX_STEP_RESET;

  tcec_pkg::result_t pending_totals[$];
  int unsigned mismatch_cnt = 0;
  int unsigned sample_cnt   = 0;
  int unsigned total_cnt    = 0;
  int unsigned back_cnt     = 0;
  int unsigned long_cnt     = 0;
  int unsigned step_cnt     = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_cnt     = 0;
  bit          gaps_on      = 1'b1;
  bit          stall_on     = 1'b1;

  // Clamped signed 64-bit add; wraparound is detectable from the sign of b
  function automatic longint clamp_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) return tcec_pkg::ACC_MAX;
    if (b < 0 && s > a) return tcec_pkg::ACC_MIN;
    return s;
  endfunction

  // Apply one sample to the mirrored state and return the totals it leaves
  function automatic tcec_pkg::result_t integrate_sample(input tcec_pkg::sample_t s);
    tcec_pkg::result_t r;
    longint  dt, a0, a1, v0, v1;
    if (!have_sample) begin
      have_sample = 1'b1;
      last_stamp  = s.time_ms;
      last_volt   = s.volt_mv;
      last_amp    = s.amp_ma;
    end else if (s.time_ms < last_stamp) begin
      run_good     = 1'b0;
      recent_fault = tcec_pkg::FAULT_BACK;
      back_cnt++;
    end else if (s.time_ms - last_stamp > {16'b0, step_limit}) begin
      run_good     = 1'b0;
      recent_fault = tcec_pkg::FAULT_LONG;
      long_cnt++;
    end else begin
      dt = {32'b0, s.time_ms - last_stamp};
      a0 = last_amp;
      a1 = s.amp_ma;
      v0 = {48'b0, last_volt};
      v1 = {48'b0, s.volt_mv};
      charge_tot = clamp_add(charge_tot, (a0 + a1) * dt);
      energy_tot = clamp_add(energy_tot, (v0 * a0 + v1 * a1) * dt);
      last_stamp = s.time_ms;
      last_volt  = s.volt_mv;
      last_amp   = s.amp_ma;
      step_cnt++;
    end
    r.charge_sum = charge_tot;
    r.energy_sum = energy_tot;
    r.run_ok     = run_good;
    r.fault_code = recent_fault;
    r.stamp_out  = last_stamp;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result channel stalls
  always @(posedge clk) begin
    if (!stall_on) begin
      result_ready <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      result_ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      hold_cnt     <= pick_gap();
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Result checker: each result word against the oldest prediction
  always @(posedge clk) begin
    tcec_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      total_cnt++;
      if (pending_totals.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result word %p", $time, result_word);
      end else begin
        want = pending_totals.pop_front();
        if (result_word.charge_sum !== want.charge_sum ||
            result_word.energy_sum !== want.energy_sum ||
            result_word.run_ok !== want.run_ok ||
            result_word.fault_code !== want.fault_code ||
            result_word.stamp_out !== want.stamp_out) begin
          mismatch_cnt++;
          $display("%0t: result mismatch", $time);
          $display("  expected charge=%0d energy=%0d ok=%0b fault=%0d stamp=%0d",
                   want.charge_sum, want.energy_sum, want.run_ok, want.fault_code,
                   want.stamp_out);
          $display("  actual   charge=%0d energy=%0d ok=%0b fault=%0d stamp=%0d",
                   result_word.charge_sum, result_word.energy_sum, result_word.run_ok,
                   result_word.fault_code, result_word.stamp_out);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress, %0d results outstanding", $time,
                 pending_totals.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Send one sample word; valid stays up if the next word follows with no gap
  task automatic send_sample(input logic [31:0] t, input logic [15:0] v,
                             input logic [15:0] a);
    tcec_pkg::sample_t s;
    int unsigned       gap;
    s.time_ms = t;
    s.volt_mv = v;
    s.amp_ma  = a;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_word  <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    pending_totals.push_back(integrate_sample(s));
    sample_cnt++;
  endtask

  // Stop sending and wait for all outstanding results
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MAX_STEP_ADDR) step_limit = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Read max_step_ms back and compare with the mirrored value
  task automatic check_step_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_STEP_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'b0, step_limit}) begin
      mismatch_cnt++;
      $display("%0t: max_step_ms readback expected %0d actual %0d", $time,
               step_limit, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_step_limit(input logic [15:0] val);
    drain_results();
    apb_write(MAX_STEP_ADDR, val);
    check_step_reg();
  endtask

  // First sample, equal stamps, limit edges, both faults, field extremes
  task automatic test_directed_steps();
    check_step_reg();
    send_sample(32'd100, 16'd3700, 16'd500);           // first sample only stored
    send_sample(32'd100, 16'd3800, -16'sd500);         // equal stamp replaces it
    send_sample(32'd150, VOLT_TOP, AMP_MOST_POS);
    send_sample(32'd1150, 16'd0, AMP_MOST_NEG);        // step exactly at the limit
    send_sample(32'd2151, 16'd4000, 16'd100);          // one past the limit
    send_sample(32'd1000, 16'd4000, 16'd100);          // backwards
    send_sample(32'd1160, 16'd3600, -16'sd1);          // integrates after a fault
    send_sample(32'd1160, VOLT_TOP, AMP_MOST_NEG);
    send_sample(32'd1161, VOLT_TOP, AMP_MOST_NEG);
    send_sample(32'd1161, 16'd0, 16'd0);
    send_sample(32'd0, 16'd0, 16'd0);                  // backwards to zero
    send_sample(32'hFFFF_FFFF, VOLT_TOP, AMP_MOST_POS); // far too long
    send_sample(32'd2000, 16'd1, 16'd1);
    drain_results();
  endtask

  // Smallest and largest max_step_ms, and a write to an unused address
  task automatic test_step_limits();
    logic [31:0] t;
    set_step_limit(16'd0);
    t = last_stamp;
    send_sample(t, 16'd3000, 16'd20);                  // dt 0 still allowed
    send_sample(t + 1, 16'd3000, 16'd20);              // anything else too long
    set_step_limit(STEP_TOP);
    t = last_stamp;
    send_sample(t + 32'd65535, 16'd4200, -16'sd300);
    send_sample(t + 32'd65535 + 32'd65536, 16'd4200, -16'sd300);
    send_sample(t + 32'd65535 + 32'd65535, 16'd4100, 16'd250);
    drain_results();
    apb_write(SPARE_ADDR, 16'd7);
    check_step_reg();
  endtask

  // Largest energy steps back to back, then the current swings the other way
  task automatic test_large_steps();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    repeat (20) send_sample(last_stamp + 32'd65535, VOLT_TOP, AMP_MOST_NEG);
    repeat (3) send_sample(last_stamp + 32'd10, VOLT_TOP, AMP_MOST_POS);
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    drain_results();
  endtask

  // Random samples: mostly good steps, some equal stamps and faults
  task automatic test_random_traffic();
    logic [15:0] limits[4];
    logic [31:0] t;
    int unsigned pick;
    limits[0] = tcec_pkg::MAX_STEP_RESET;
    limits[1] = 16'($urandom_range(1, 65534));
    limits[2] = 16'd3;
    limits[3] = STEP_TOP;
    for (int ph = 0; ph < 4; ph++) begin
      set_step_limit(limits[ph]);
      gaps_on = (ph != 2);
      for (int n = 0; n < 90; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          t = last_stamp + $urandom_range(0, step_limit);
        end else if (pick < 85) begin
          t = last_stamp;
        end else if (pick < 93 && last_stamp != 0) begin
          t = $urandom_range(0, last_stamp - 1);
        end else begin
          t = $urandom_range(last_stamp + step_limit + 1, 32'hFFFF_FFFF);
        end
        send_sample(t, 16'($urandom), 16'($urandom));
      end
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_steps();
    test_step_limits();
    test_large_steps();
    test_random_traffic();
    set_step_limit(tcec_pkg::MAX_STEP_RESET);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d samples and %0d results: %0d integrated,",
             sample_cnt, total_cnt, step_cnt);
    $display("%0d backwards, %0d too long, mismatches: %0d",
             back_cnt, long_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && pending_totals.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
